// File: hdl/md5de_pkg.sv
// ----------------------------------------------------------------------------
// MD5 digest engine package
// Shared types, constants and round tables of the MD5 digest engine.
// ----------------------------------------------------------------------------
package md5de_pkg;

  localparam int unsigned WORDS      = 16;
  localparam int unsigned WADDR_W    = 4;
  localparam int unsigned BPOS_W     = 6;
  localparam int unsigned ROUND_W    = 6;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Word positions inside a block during padding, and other last-index limits.
  localparam logic [WADDR_W:0]   LAST_ZERO_SHORT = 5'd13;
  localparam logic [WADDR_W:0]   LAST_ZERO_FULL  = 5'd15;
  localparam logic [WADDR_W-1:0] LEN_LO_WORD     = 4'd14;
  localparam logic [WADDR_W-1:0] LEN_HI_WORD     = 4'd15;
  localparam logic [ROUND_W-1:0] LAST_ROUND      = 6'd63;
  localparam logic [BPOS_W-1:0]  LAST_BYTE_POS   = 6'd63;
  localparam logic [1:0]         LAST_LANE       = 2'd3;
  localparam logic [1:0]         LAST_WORD_IDX   = 2'd3;
  localparam logic [2:0]         LEN_AREA_OCTET  = 3'd7;

  typedef enum logic [2:0] {
    WSEL_BYTE,
    WSEL_PAD,
    WSEL_ZERO,
    WSEL_LEN_LO,
    WSEL_LEN_HI
  } wsel_t;

  typedef struct packed {
    logic                 byte_we;
    logic                 ram_we;
    wsel_t                wsel;
    logic [WADDR_W-1:0]   waddr;
    logic [WADDR_W-1:0]   raddr;
    logic                 rnd_load;
    logic                 rnd_step;
    logic [ROUND_W-1:0]   rnd;
    logic                 chain_add;
    logic                 ctx_init;
    logic [1:0]           oidx;
  } cmd_t;

  typedef struct packed {
    logic [BPOS_W-1:0] pos;
  } stat_t;

  function automatic logic [31:0] round_const(input logic [ROUND_W-1:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [ROUND_W-1:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  // Message word used by a round; all arithmetic is modulo 16.
  function automatic logic [WADDR_W-1:0] msg_index(input logic [ROUND_W-1:0] i);
    logic [WADDR_W-1:0] j;
    logic [WADDR_W-1:0] g;
    j = i[3:0];
    case (i[5:4])
      2'd0:    g = j;
      2'd1:    g = 4'(j * 4'd5 + 4'd1);
      2'd2:    g = 4'(j * 4'd3 + 4'd5);
      default: g = 4'(j * 4'd7);
    endcase
    return g;
  endfunction

endpackage

// File: hdl/md5de_if.sv
// ----------------------------------------------------------------------------
// MD5 digest engine channels
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface md5de_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface md5de_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: hdl/md5de_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module md5de_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: hdl/md5de_ctrl.sv
// ----------------------------------------------------------------------------
// MD5 digest engine controller
// Sequences byte intake, padding, compression rounds and digest transfer.
// ----------------------------------------------------------------------------
module md5de_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_present,
  input  logic             in_end,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  md5de_pkg::stat_t stat,
  output md5de_pkg::cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_HEAD   = 9'b000000010,
    S_ZERO   = 9'b000000100,
    S_LEN_LO = 9'b000001000,
    S_LEN_HI = 9'b000010000,
    S_PRE    = 9'b000100000,
    S_RND    = 9'b001000000,
    S_ADD    = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_HEAD,
    RET_PAD2,
    RET_OUT
  } ret_t;

  state_t                        state_r, state_nxt;
  ret_t                          ret_r, ret_nxt;
  logic [md5de_pkg::WADDR_W:0]   wcnt_r, wcnt_nxt;
  logic                          lim_hi_r, lim_hi_nxt;
  logic [md5de_pkg::ROUND_W-1:0] rnd_r, rnd_nxt;
  logic [1:0]                    oidx_r, oidx_nxt;
  logic [md5de_pkg::WADDR_W:0]   lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= RET_IDLE;
      wcnt_r   <= '0;
      lim_hi_r <= 1'b0;
      rnd_r    <= '0;
      oidx_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      wcnt_r   <= wcnt_nxt;
      lim_hi_r <= lim_hi_nxt;
      rnd_r    <= rnd_nxt;
      oidx_r   <= oidx_nxt;
    end
  end

  assign lim = lim_hi_r ? md5de_pkg::LAST_ZERO_FULL : md5de_pkg::LAST_ZERO_SHORT;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    wcnt_nxt      = wcnt_r;
    lim_hi_nxt    = lim_hi_r;
    rnd_nxt       = rnd_r;
    oidx_nxt      = oidx_r;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    cmd.wsel      = md5de_pkg::WSEL_BYTE;
    cmd.rnd       = rnd_r;
    cmd.oidx      = oidx_r;
    cmd.raddr     = md5de_pkg::msg_index(6'(rnd_r + 6'd1));
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_present) begin
            cmd.byte_we = 1'b1;
            cmd.waddr   = stat.pos[5:2];
            cmd.ram_we  = (stat.pos[1:0] == md5de_pkg::LAST_LANE);
            if (stat.pos == md5de_pkg::LAST_BYTE_POS) begin
              state_nxt = S_PRE;
              ret_nxt   = in_end ? RET_HEAD : RET_IDLE;
            end else if (in_end) begin
              state_nxt = S_HEAD;
            end
          end else if (in_end) begin
            state_nxt = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        cmd.ram_we = 1'b1;
        cmd.wsel   = md5de_pkg::WSEL_PAD;
        cmd.waddr  = stat.pos[5:2];
        wcnt_nxt   = {1'b0, stat.pos[5:2]} + 5'd1;
        lim_hi_nxt = (stat.pos[5:3] == md5de_pkg::LEN_AREA_OCTET);
        state_nxt  = S_ZERO;
      end
      S_ZERO: begin
        if (wcnt_r <= lim) begin
          cmd.ram_we = 1'b1;
          cmd.wsel   = md5de_pkg::WSEL_ZERO;
          cmd.waddr  = wcnt_r[3:0];
          wcnt_nxt   = wcnt_r + 5'd1;
        end else if (lim_hi_r) begin
          state_nxt = S_PRE;
          ret_nxt   = RET_PAD2;
        end else begin
          state_nxt = S_LEN_LO;
        end
      end
      S_LEN_LO: begin
        cmd.ram_we = 1'b1;
        cmd.wsel   = md5de_pkg::WSEL_LEN_LO;
        cmd.waddr  = md5de_pkg::LEN_LO_WORD;
        state_nxt  = S_LEN_HI;
      end
      S_LEN_HI: begin
        cmd.ram_we = 1'b1;
        cmd.wsel   = md5de_pkg::WSEL_LEN_HI;
        cmd.waddr  = md5de_pkg::LEN_HI_WORD;
        state_nxt  = S_PRE;
        ret_nxt    = RET_OUT;
      end
      S_PRE: begin
        // Fetch the first round's word while the working registers load.
        cmd.raddr    = md5de_pkg::msg_index('0);
        cmd.rnd_load = 1'b1;
        rnd_nxt      = '0;
        state_nxt    = S_RND;
      end
      S_RND: begin
        cmd.rnd_step = 1'b1;
        rnd_nxt      = 6'(rnd_r + 6'd1);
        if (rnd_r == md5de_pkg::LAST_ROUND) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.chain_add = 1'b1;
        case (ret_r)
          RET_IDLE: state_nxt = S_IDLE;
          RET_HEAD: state_nxt = S_HEAD;
          RET_PAD2: begin
            wcnt_nxt   = '0;
            lim_hi_nxt = 1'b0;
            state_nxt  = S_ZERO;
          end
          RET_OUT: begin
            oidx_nxt  = '0;
            state_nxt = S_OUT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (oidx_r == md5de_pkg::LAST_WORD_IDX) begin
            cmd.ctx_init = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            oidx_nxt = oidx_r + 2'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: hdl/md5de_dpath.sv
// ----------------------------------------------------------------------------
// MD5 digest engine datapath
// Chaining value, bit count, word assembly, block store and round unit.
// ----------------------------------------------------------------------------
module md5de_dpath (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       data_byte,
  input  md5de_pkg::cmd_t  cmd,
  output md5de_pkg::stat_t stat,
  output logic [31:0]      digest_word
);

  logic [31:0] chain_r [4];
  logic [63:0] bit_count_r;
  logic [31:0] asm_r;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] wdata, rdata, asm_word, pad_word;
  logic [31:0] f, t, rot_b;
  logic [63:0] dbl;
  logic [1:0]  lane;

  assign stat.pos    = bit_count_r[8:3];
  assign lane        = bit_count_r[4:3];
  assign digest_word = chain_r[cmd.oidx];

  always_comb begin
    asm_word = asm_r;
    pad_word = '0;
    for (int l = 0; l < 4; l++) begin
      if (2'(l) == lane) begin
        asm_word[8*l +: 8] = data_byte;
        pad_word[8*l +: 8] = md5de_pkg::PAD_BYTE;
      end else if (2'(l) < lane) begin
        pad_word[8*l +: 8] = asm_r[8*l +: 8];
      end
    end
  end

  always_comb begin
    case (cmd.wsel)
      md5de_pkg::WSEL_BYTE:   wdata = asm_word;
      md5de_pkg::WSEL_PAD:    wdata = pad_word;
      md5de_pkg::WSEL_LEN_LO: wdata = bit_count_r[31:0];
      md5de_pkg::WSEL_LEN_HI: wdata = bit_count_r[63:32];
      default:                wdata = '0;
    endcase
  end

  md5de_ram #(.WIDTH(32), .DEPTH(md5de_pkg::WORDS)) u_store (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (cmd.waddr),
    .wdata (wdata),
    .raddr (cmd.raddr),
    .rdata (rdata)
  );

  // One MD5 round per cycle.
  always_comb begin
    case (cmd.rnd[5:4])
      2'd0:    f = d_r ^ (b_r & (c_r ^ d_r));
      2'd1:    f = c_r ^ (d_r & (b_r ^ c_r));
      2'd2:    f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    t     = a_r + f + rdata + md5de_pkg::round_const(cmd.rnd);
    dbl   = {t, t} << md5de_pkg::rot_amount(cmd.rnd);
    rot_b = b_r + dbl[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r[0]  <= md5de_pkg::IV_A;
      chain_r[1]  <= md5de_pkg::IV_B;
      chain_r[2]  <= md5de_pkg::IV_C;
      chain_r[3]  <= md5de_pkg::IV_D;
      bit_count_r <= '0;
    end else if (cmd.ctx_init) begin
      chain_r[0]  <= md5de_pkg::IV_A;
      chain_r[1]  <= md5de_pkg::IV_B;
      chain_r[2]  <= md5de_pkg::IV_C;
      chain_r[3]  <= md5de_pkg::IV_D;
      bit_count_r <= '0;
    end else begin
      if (cmd.byte_we) begin
        bit_count_r <= bit_count_r + 64'd8;
      end
      if (cmd.chain_add) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_we) begin
      asm_r <= asm_word;
    end
    if (cmd.rnd_load) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
    end else if (cmd.rnd_step) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= rot_b;
    end
  end

endmodule

// File: hdl/md5_digest_engine_unit.sv
// ----------------------------------------------------------------------------
// MD5 digest engine
// Streaming MD5 over a byte stream with a four-word digest output.
// ----------------------------------------------------------------------------
// A byte item is taken whenever the engine is idle. When a byte completes a
// 64-byte block, the block is compressed (a load step, 64 rounds through a
// single round unit, one chaining add) and no input is taken meanwhile. An
// item that ends the message starts padding: the 0x80 word, the zero words up
// to word 13, the two bit-length words and a compression; when fewer than
// nine bytes are left in the block, the zero words run to word 15 and a
// second compression and its zero words follow. The four digest words then
// leave as four transfers, word 0 first, each holding its earliest byte in
// bits 7:0. After the last transfer the chaining value and bit count return
// to their initial values, so the next byte begins a new message. These
// steps follow from the controller sequencing a word store with one write
// and one read port and one shared round unit.
// ----------------------------------------------------------------------------
module md5_digest_engine_unit (
  input logic        clk,
  input logic        rst_n,
  md5de_in_if.sink   in_ch,
  md5de_out_if.source out_ch
);

  md5de_pkg::cmd_t  cmd;
  md5de_pkg::stat_t stat;

  // The controller owns both handshakes; the datapath only follows commands.
  md5de_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_present (in_ch.byte_present),
    .in_end     (in_ch.end_of_message),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  md5de_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .data_byte   (in_ch.data_byte),
    .cmd         (cmd),
    .stat        (stat),
    .digest_word (out_ch.digest_word)
  );

  // The word index comes straight from the controller's output counter.
  assign out_ch.word_index = cmd.oidx;
  assign out_ch.last_word  = (cmd.oidx == md5de_pkg::LAST_WORD_IDX);

endmodule

// File: hdl/md5de_checker.sv
// ----------------------------------------------------------------------------
// MD5 digest engine checker
// Port-level properties of the digest engine, bound to the top level.
// ----------------------------------------------------------------------------
module md5de_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] word_index,
  input logic       last_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(word_index))
    else $error("digest word withdrawn before transfer");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while digest is pending");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_word |=>
      out_valid && word_index == 2'($past(word_index) + 2'd1))
    else $error("digest words out of order");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last_word |=> !out_valid && in_ready)
    else $error("engine not idle after final digest word");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last_word == (word_index == 2'd3)))
    else $error("last flag does not match word index");

endmodule

bind md5_digest_engine_unit md5de_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .word_index (out_ch.word_index),
  .last_word  (out_ch.last_word)
);
